// ----- src/h4rx_pkg.sv -----
// Shared types and constants for the H4 receive deframer with eHCILL tracking.
// Used by the front classifier, the parser back end and the top level.
// No dependencies.
package h4rx_pkg;

  // H4 packet type bytes.
  localparam logic [7:0] TypeAcl   = 8'h02;
  localparam logic [7:0] TypeEvent = 8'h04;

  // eHCILL command bytes.
  localparam logic [7:0] SleepInd = 8'h30;
  localparam logic [7:0] SleepAck = 8'h31;
  localparam logic [7:0] WakeInd  = 8'h32;
  localparam logic [7:0] WakeAck  = 8'h33;

  // Header lengths counted after the type byte.
  localparam logic [2:0] AclHdrLen   = 3'd4;
  localparam logic [2:0] EventHdrLen = 3'd2;

  // Result kinds.
  localparam logic [1:0] KindPacket  = 2'd0;
  localparam logic [1:0] KindCommand = 2'd1;
  localparam logic [1:0] KindInvalid = 2'd2;

  // Reply requests.
  localparam logic [1:0] ReplyNone  = 2'd0;
  localparam logic [1:0] ReplySleep = 2'd1;
  localparam logic [1:0] ReplyWake  = 2'd2;

  // Queue between the front and back parts.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;

  // One received byte with its state-independent decode.
  typedef struct packed {
    logic [7:0] data;
    logic       type_acl;
    logic       type_event;
    logic       cmd;
    logic       sleep_ind;
    logic       wake_ind;
  } rx_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       is_acl;
    logic       first;
    logic       last;
    logic [1:0] reply_request;
    logic       asleep;
  } rx_result_t;

endpackage

// ----- src/h4rx_front.sv -----
// Front part of the deframer: accepts received bytes, decodes them and
// holds them in a short queue for the parser. Depends on h4rx_pkg.
module h4rx_front
  import h4rx_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_data_i,
  output logic       item_valid_o,
  input  logic       item_pop_i,
  output rx_item_t   item_o
);

  rx_item_t                 queue_q [QueueDepth];
  logic [QueuePtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]       count_q, count_d;
  rx_item_t                 decoded;
  logic                     push;
  logic                     pop;

  // Decode the byte before it enters the queue.
  always_comb begin
    decoded.data       = in_data_i;
    decoded.type_acl   = (in_data_i == TypeAcl);
    decoded.type_event = (in_data_i == TypeEvent);
    decoded.cmd        = (in_data_i inside {[SleepInd:WakeAck]});
    decoded.sleep_ind  = (in_data_i == SleepInd);
    decoded.wake_ind   = (in_data_i == WakeInd);
  end

  assign in_ready_o   = (count_q != (QueuePtrW+1)'(QueueDepth));
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (count_q != '0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = queue_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= decoded;
    end
  end

endmodule

// ----- src/h4rx_back.sv -----
// Back part of the deframer: the H4 packet parser, the eHCILL power state
// and the output register. Depends on h4rx_pkg.
module h4rx_back
  import h4rx_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  output logic       item_pop_o,
  input  rx_item_t   item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rx_result_t out_o
);

  localparam logic [1:0] PhType    = 2'd0;
  localparam logic [1:0] PhHeader  = 2'd1;
  localparam logic [1:0] PhPayload = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic [15:0] remaining_q, remaining_d;
  logic        acl_q, acl_d;
  logic [7:0]  len_low_q, len_low_d;
  logic        sleeping_q, sleeping_d;
  logic        out_valid_q;
  rx_result_t  out_q, res;
  logic [2:0]  hdr_inc;
  logic [15:0] rem_dec;
  logic [15:0] hdr_len;
  logic        pop;

  // Take the next item whenever the output register is free or draining.
  assign pop        = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_pop_o = pop;
  assign hdr_inc    = hdr_cnt_q + 3'd1;
  assign rem_dec    = remaining_q - 16'd1;
  assign hdr_len    = acl_q ? {item_i.data, len_low_q} : {8'd0, item_i.data};

  // Per-byte parser step.
  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    remaining_d = remaining_q;
    acl_d       = acl_q;
    len_low_d   = len_low_q;
    sleeping_d  = sleeping_q;

    res.kind          = KindPacket;
    res.data_byte     = item_i.data;
    res.is_acl        = 1'b0;
    res.first         = 1'b0;
    res.last          = 1'b0;
    res.reply_request = ReplyNone;

    case (phase_q)
      PhHeader: begin
        res.is_acl = acl_q;
        hdr_cnt_d  = hdr_inc;
        if (acl_q && hdr_inc == 3'd3) begin
          len_low_d = item_i.data;
        end
        if (hdr_inc >= (acl_q ? AclHdrLen : EventHdrLen)) begin
          hdr_cnt_d = '0;
          if (hdr_len == '0) begin
            res.last    = 1'b1;
            phase_d     = PhType;
            remaining_d = '0;
          end else begin
            remaining_d = hdr_len;
            phase_d     = PhPayload;
          end
        end
      end
      PhPayload: begin
        res.is_acl  = acl_q;
        remaining_d = rem_dec;
        if (rem_dec == '0) begin
          res.last = 1'b1;
          phase_d  = PhType;
        end
      end
      default: begin
        // Type position; the unused phase code lands here too.
        phase_d = PhType;
        if (item_i.type_acl || item_i.type_event) begin
          acl_d       = item_i.type_acl;
          res.is_acl  = item_i.type_acl;
          res.first   = 1'b1;
          hdr_cnt_d   = '0;
          remaining_d = '0;
          len_low_d   = '0;
          phase_d     = PhHeader;
        end else if (item_i.cmd) begin
          res.kind = KindCommand;
          if (!sleeping_q && item_i.sleep_ind) begin
            sleeping_d        = 1'b1;
            res.reply_request = ReplySleep;
          end else if (sleeping_q && item_i.wake_ind) begin
            sleeping_d        = 1'b0;
            res.reply_request = ReplyWake;
          end
        end else begin
          res.kind = KindInvalid;
        end
      end
    endcase

    res.asleep = sleeping_d;
  end

  // Parser state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhType;
      hdr_cnt_q   <= '0;
      remaining_q <= '0;
      acl_q       <= 1'b0;
      len_low_q   <= '0;
      sleeping_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        phase_q     <= phase_d;
        hdr_cnt_q   <= hdr_cnt_d;
        remaining_q <= remaining_d;
        acl_q       <= acl_d;
        len_low_q   <= len_low_d;
        sleeping_q  <= sleeping_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ----- src/h4_hci_rx_deframer_ehcill_top.sv -----
// H4 receive deframer with eHCILL power-state tracking, top level.
// Depends on h4rx_pkg, h4rx_front and h4rx_back.
//
// Usage:
//   The slave channel takes one received UART byte per transfer in
//   s_axis_tdata. For every byte the master channel gives one result:
//   m_axis_tuser holds the kind (packet byte, eHCILL command, invalid type
//   byte) and the ACL flag, m_axis_tlast marks the final byte of a packet,
//   and m_axis_tdata holds the echoed byte, the first-byte mark, the reply
//   request (sleep or wake-up acknowledgement) and the power state after
//   the byte.
//   An input transfer passes through the two-entry decode queue and then
//   the parser's output register before it can leave as an output
//   transfer. Throughput is one byte per cycle while the receiver keeps
//   up. When the receiver stalls, the output register holds its result
//   and the queue absorbs up to two more bytes before s_axis_tready
//   drops; the parser resumes at full rate once it drains.
//   Reset empties the queue and the output register, puts the parser in
//   type position and marks the link awake.
module h4_hci_rx_deframer_ehcill_top
  import h4rx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [8] first,
                                      // [10:9] reply_request, [11] asleep,
                                      // [15:12] zero
  output logic [2:0]  m_axis_tuser,   // [1:0] kind, [2] is_acl
  output logic        m_axis_tlast    // last
);

  logic       item_valid;
  logic       item_pop;
  rx_item_t   item;
  rx_result_t result;

  // Front part: byte intake, decode and queue.
  h4rx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop),
    .item_o       (item)
  );

  // Back part: packet parser and power state.
  h4rx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .item_i       (item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (result)
  );

  // Pack the result onto the master channel.
  assign m_axis_tdata = {4'd0, result.asleep, result.reply_request, result.first,
                         result.data_byte};
  assign m_axis_tuser = {result.is_acl, result.kind};
  assign m_axis_tlast = result.last;

endmodule
